FILE: hdl/web_mercator_projection_assert.svh
// assertion macros for the web mercator projection checker
`ifndef WEB_MERCATOR_PROJECTION_ASSERT_SVH
`define WEB_MERCATOR_PROJECTION_ASSERT_SVH

// same-cycle implication, sampled on i_clk, off while reset is held
`define WMP_ASSERT_NOW(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error("web mercator port check failed");

// next-cycle implication, sampled on i_clk, off while reset is held
`define WMP_ASSERT_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error("web mercator port check failed");

`endif

FILE: hdl/wmp_pkg.sv
// shared types, constants and elaboration-time functions for the web mercator block
`timescale 1ns / 1ps

package wmp_pkg;

    localparam int FIELD_W  = 58;
    localparam int TDATA_W  = 176;
    localparam int CFG_IDX_W = 2;

    localparam logic [CFG_IDX_W-1:0] REG_MERCATOR_ENABLED = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_FALSE_EASTING    = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_FALSE_NORTHING   = 2'd2;

    localparam logic signed [63:0] ONE_Q60 = 64'sh1000_0000_0000_0000;
    localparam logic signed [63:0] PI_Q60  = 64'sh3243_F6A8_885A_308D;
    localparam logic signed [63:0] LN2_Q60 = 64'sh0B17_217F_7D1C_F79B;
    localparam logic signed [63:0] LIM62   = 64'sh4000_0000_0000_0000;
    localparam logic signed [63:0] EARTH_R = 64'sd6378137;
    localparam logic signed [63:0] FIELD_MAX = (64'sd1 <<< (FIELD_W - 1)) - 64'sd1;
    localparam logic signed [63:0] FIELD_MIN = -(64'sd1 <<< (FIELD_W - 1));

    typedef struct packed {
        logic                enabled;
        logic signed [63:0]  false_easting;
        logic signed [63:0]  false_northing;
    } t_cfg;

    // long division by shift and subtract, low 64 quotient bits
    function automatic logic [63:0] udiv128(logic [127:0] num, logic [63:0] d);
        logic [64:0] r;
        logic [63:0] q;
        r = '0;
        q = '0;
        for (int b = 127; b >= 0; b--) begin
            r = {r[63:0], num[b]};
            q = {q[62:0], 1'b0};
            if (r >= {1'b0, d}) begin
                r = r - {1'b0, d};
                q[0] = 1'b1;
            end
        end
        return q;
    endfunction

    function automatic logic [63:0] mul_round(logic [63:0] a, logic [63:0] b, int s);
        logic [127:0] p;
        p = {64'd0, a} * {64'd0, b};
        p = p + (128'd1 << (s - 1));
        p = p >> s;
        return p[63:0];
    endfunction

    // arctan or artanh of 2^-i by power series, Q60
    function automatic logic [63:0] series(int i, bit alternating);
        logic [63:0] sum;
        logic [63:0] t;
        int e;
        sum = '0;
        for (int k = 0; k < 32; k++) begin
            e = i * (2 * k + 1);
            if (e <= 63) begin
                t = udiv128(128'd1 << (63 - e), 64'(2 * k + 1));
                if (alternating && (k % 2 == 1)) sum = sum - t;
                else sum = sum + t;
            end
        end
        return (sum + 64'd4) >> 3;
    endfunction

    function automatic logic signed [63:0] circ_atan(int i);
        if (i == 0) return signed'((64'(PI_Q60) + 64'd2) >> 2);
        return signed'(series(i, 1'b1));
    endfunction

    function automatic logic signed [63:0] hyp_atanh(int i);
        return signed'(series(i, 1'b0));
    endfunction

    function automatic int hyp_iters(int n);
        int cnt;
        cnt = 0;
        for (int i = 1; i <= n; i++) cnt += (i == 4 || i == 13 || i == 40) ? 2 : 1;
        return cnt;
    endfunction

    // shift of hyperbolic iteration j, with shifts 4, 13 and 40 taken twice
    function automatic int hyp_shift(int j, int n);
        int cnt;
        int sh;
        cnt = 0;
        sh = 1;
        for (int i = 1; i <= n; i++) begin
            for (int r = 0; r < ((i == 4 || i == 13 || i == 40) ? 2 : 1); r++) begin
                if (cnt == j) sh = i;
                cnt++;
            end
        end
        return sh;
    endfunction

    function automatic int path_lat(int cs);
        return hyp_iters(cs) + cs + 15;
    endfunction

    function automatic logic signed [63:0] lat_max(int fb);
        logic [63:0] v;
        v = (64'd85 << fb) + (((64'd5112878 << fb) + 64'd50000000) / 64'd100000000);
        return signed'(v);
    endfunction

    function automatic logic signed [63:0] clamp_lat(logic signed [63:0] v,
                                                     logic signed [63:0] lim);
        if (v > lim) return lim;
        if (v < -lim) return -lim;
        return v;
    endfunction

    function automatic logic [FIELD_W-1:0] sat_field(logic signed [63:0] v);
        if (v > FIELD_MAX) return FIELD_MAX[FIELD_W-1:0];
        if (v < FIELD_MIN) return FIELD_MIN[FIELD_W-1:0];
        return v[FIELD_W-1:0];
    endfunction

    function automatic logic signed [63:0] sext_field(logic [FIELD_W-1:0] v);
        return signed'({{(64 - FIELD_W){v[FIELD_W-1]}}, v});
    endfunction

    localparam logic signed [63:0] KDEG57 = signed'(udiv128({64'd180 << 53, 64'd0}, 64'(PI_Q60)));
    localparam logic signed [63:0] KRAD68 =
        signed'(udiv128({64'(PI_Q60) >> 56, 64'(PI_Q60) << 8}, 64'd180));
    localparam logic signed [63:0] INVR85 = signed'(udiv128({64'd1 << 21, 64'd0}, 64'(EARTH_R)));
    localparam logic signed [63:0] CLON78 = signed'(mul_round(64'(KDEG57), 64'(INVR85), 64));
    localparam logic signed [63:0] CX46   = signed'(mul_round(64'(EARTH_R), 64'(KRAD68), 22));

endpackage

FILE: hdl/wmp_smul.sv
// pipelined signed multiply with round half away from zero, shift and magnitude limit
`timescale 1ns / 1ps

module wmp_smul #(
    parameter int          SHIFT = 60,
    parameter logic [63:0] LIM   = 64'h4000_0000_0000_0000
) (
    input  logic               i_clk,
    input  logic               i_en,
    input  logic signed [63:0] i_a,
    input  logic signed [63:0] i_b,
    output logic signed [63:0] o_p
);

    logic [63:0]  r_ua, r_ub;
    logic         r_neg1, r_neg2, r_neg3;
    logic [63:0]  r_p00, r_p01, r_p10, r_p11;
    logic [127:0] r_prod;
    logic signed [63:0] r_out;

    logic [128:0] n_rnd;
    logic [128:0] n_q;
    logic [63:0]  n_mag;

    always_comb begin
        n_rnd = {1'b0, r_prod} + (129'd1 << (SHIFT - 1));
        n_q   = n_rnd >> SHIFT;
        n_mag = ((|n_q[128:64]) || (n_q[63:0] > LIM)) ? LIM : n_q[63:0];
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_ua   <= i_a[63] ? 64'(-i_a) : 64'(i_a);
            r_ub   <= i_b[63] ? 64'(-i_b) : 64'(i_b);
            r_neg1 <= i_a[63] ^ i_b[63];
            r_p00  <= r_ua[31:0] * r_ub[31:0];
            r_p01  <= r_ua[31:0] * r_ub[63:32];
            r_p10  <= r_ua[63:32] * r_ub[31:0];
            r_p11  <= r_ua[63:32] * r_ub[63:32];
            r_neg2 <= r_neg1;
            r_prod <= {64'd0, r_p00} + {32'd0, r_p01, 32'd0} + {32'd0, r_p10, 32'd0}
                      + {r_p11, 64'd0};
            r_neg3 <= r_neg2;
            r_out  <= r_neg3 ? -signed'(n_mag) : signed'(n_mag);
        end
    end

    assign o_p = r_out;

endmodule

FILE: hdl/wmp_delay.sv
// enable-gated delay line for side data traveling beside the arithmetic
`timescale 1ns / 1ps

module wmp_delay #(
    parameter int WIDTH = 1,
    parameter int DEPTH = 1
) (
    input  logic             i_clk,
    input  logic             i_en,
    input  logic [WIDTH-1:0] i_d,
    output logic [WIDTH-1:0] o_q
);

    logic [WIDTH-1:0] r_pipe [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_pipe[0] <= i_d;
            for (int k = 1; k < DEPTH; k++) r_pipe[k] <= r_pipe[k-1];
        end
    end

    assign o_q = r_pipe[DEPTH-1];

endmodule

FILE: hdl/wmp_cordic.sv
// unrolled cordic, one register stage per iteration, circular or hyperbolic
`timescale 1ns / 1ps

module wmp_cordic #(
    parameter int STAGES = 40,
    parameter bit HYP    = 1'b0,
    parameter bit VEC    = 1'b0
) (
    input  logic               i_clk,
    input  logic               i_en,
    input  logic signed [63:0] i_x,
    input  logic signed [63:0] i_y,
    input  logic signed [63:0] i_z,
    output logic signed [63:0] o_x,
    output logic signed [63:0] o_y,
    output logic signed [63:0] o_z
);

    localparam int N = HYP ? wmp_pkg::hyp_iters(STAGES) : STAGES;

    logic signed [63:0] r_x [N];
    logic signed [63:0] r_y [N];
    logic signed [63:0] r_z [N];
    logic signed [63:0] n_x [N];
    logic signed [63:0] n_y [N];
    logic signed [63:0] n_z [N];

    for (genvar g = 0; g < N; g++) begin : g_stage
        localparam int SH = HYP ? wmp_pkg::hyp_shift(g, STAGES) : g;
        localparam logic signed [63:0] ANG = HYP ? wmp_pkg::hyp_atanh(SH)
                                                 : wmp_pkg::circ_atan(SH);
        logic signed [63:0] x_in, y_in, z_in, dx, dy;
        logic sig;
        if (g == 0) begin : g_head
            assign x_in = i_x;
            assign y_in = i_y;
            assign z_in = i_z;
        end else begin : g_body
            assign x_in = r_x[g-1];
            assign y_in = r_y[g-1];
            assign z_in = r_z[g-1];
        end
        assign dx  = y_in >>> SH;
        assign dy  = x_in >>> SH;
        // rotation follows the residual angle, vectoring drives y to zero
        assign sig = VEC ? y_in[63] : !z_in[63];
        assign n_x[g] = (sig ^ HYP) ? x_in - dx : x_in + dx;
        assign n_y[g] = sig ? y_in + dy : y_in - dy;
        assign n_z[g] = sig ? z_in - ANG : z_in + ANG;
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            for (int k = 0; k < N; k++) begin
                r_x[k] <= n_x[k];
                r_y[k] <= n_y[k];
                r_z[k] <= n_z[k];
            end
        end
    end

    assign o_x = r_x[N-1];
    assign o_y = r_y[N-1];
    assign o_z = r_z[N-1];

endmodule

FILE: hdl/wmp_to_geo.sv
// projected meters to geographic degrees: longitude scale and gudermannian latitude
`timescale 1ns / 1ps

module wmp_to_geo #(
    parameter int FRACTION_BITS = 32,
    parameter int CORDIC_STAGES = 40
) (
    input  logic                         i_clk,
    input  logic                         i_en,
    input  wmp_pkg::t_cfg                i_cfg,
    input  logic signed [63:0]           i_east,
    input  logic signed [63:0]           i_north,
    output logic [wmp_pkg::FIELD_W-1:0]  o_lat,
    output logic [wmp_pkg::FIELD_W-1:0]  o_lon
);

    localparam int H = wmp_pkg::hyp_iters(CORDIC_STAGES);
    localparam logic signed [63:0] LAT_MAX = wmp_pkg::lat_max(FRACTION_BITS);

    logic signed [63:0] r_x, r_y, r_vx, r_vy, r_lat;
    logic signed [63:0] w_lon, w_w, w_c, w_s, w_cc, w_ss, w_cs, w_th, w_lat;

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_x   <= i_east - i_cfg.false_easting;
            r_y   <= i_north - i_cfg.false_northing;
            r_vx  <= w_cc + w_ss;
            r_vy  <= w_cs;
            r_lat <= wmp_pkg::clamp_lat(w_lat, LAT_MAX);
        end
    end

    wmp_smul #(.SHIFT(78), .LIM(64'(wmp_pkg::LIM62))) u_lon (
        .i_clk(i_clk), .i_en(i_en), .i_a(r_x), .i_b(wmp_pkg::CLON78), .o_p(w_lon)
    );

    wmp_delay #(.WIDTH(wmp_pkg::FIELD_W), .DEPTH(H + CORDIC_STAGES + 10)) u_lon_dly (
        .i_clk(i_clk), .i_en(i_en), .i_d(wmp_pkg::sat_field(w_lon)), .o_q(o_lon)
    );

    // y / (4R)
    wmp_smul #(.SHIFT(FRACTION_BITS + 27), .LIM(64'(wmp_pkg::ONE_Q60))) u_w (
        .i_clk(i_clk), .i_en(i_en), .i_a(r_y), .i_b(wmp_pkg::INVR85), .o_p(w_w)
    );

    wmp_cordic #(.STAGES(CORDIC_STAGES), .HYP(1'b1), .VEC(1'b0)) u_hrot (
        .i_clk(i_clk), .i_en(i_en), .i_x(wmp_pkg::ONE_Q60), .i_y(64'sd0), .i_z(w_w),
        .o_x(w_c), .o_y(w_s), .o_z()
    );

    // double angle: cosh and sinh of y/(2R)
    wmp_smul #(.SHIFT(61), .LIM(64'(wmp_pkg::LIM62))) u_cc (
        .i_clk(i_clk), .i_en(i_en), .i_a(w_c), .i_b(w_c), .o_p(w_cc)
    );
    wmp_smul #(.SHIFT(61), .LIM(64'(wmp_pkg::LIM62))) u_ss (
        .i_clk(i_clk), .i_en(i_en), .i_a(w_s), .i_b(w_s), .o_p(w_ss)
    );
    wmp_smul #(.SHIFT(60), .LIM(64'(wmp_pkg::LIM62))) u_cs (
        .i_clk(i_clk), .i_en(i_en), .i_a(w_c), .i_b(w_s), .o_p(w_cs)
    );

    wmp_cordic #(.STAGES(CORDIC_STAGES), .HYP(1'b0), .VEC(1'b1)) u_cvec (
        .i_clk(i_clk), .i_en(i_en), .i_x(r_vx), .i_y(r_vy), .i_z(64'sd0),
        .o_x(), .o_y(), .o_z(w_th)
    );

    wmp_smul #(.SHIFT(116 - FRACTION_BITS), .LIM(64'(wmp_pkg::LIM62))) u_deg (
        .i_clk(i_clk), .i_en(i_en), .i_a(w_th), .i_b(wmp_pkg::KDEG57), .o_p(w_lat)
    );

    assign o_lat = r_lat[wmp_pkg::FIELD_W-1:0];

endmodule

FILE: hdl/wmp_to_proj.sv
// geographic degrees to projected meters: longitude scale and log-tangent northing
`timescale 1ns / 1ps

module wmp_to_proj #(
    parameter int FRACTION_BITS = 32,
    parameter int CORDIC_STAGES = 40
) (
    input  logic                         i_clk,
    input  logic                         i_en,
    input  wmp_pkg::t_cfg                i_cfg,
    input  logic signed [63:0]           i_lat,
    input  logic signed [63:0]           i_lon,
    output logic [wmp_pkg::FIELD_W-1:0]  o_east,
    output logic [wmp_pkg::FIELD_W-1:0]  o_north
);

    localparam int H = wmp_pkg::hyp_iters(CORDIC_STAGES);
    localparam logic signed [63:0] LAT_MAX = wmp_pkg::lat_max(FRACTION_BITS);

    logic signed [63:0] r_lat, r_h, r_a, r_b, r_a2, r_b2, r_u, r_v, r_len;
    logic [wmp_pkg::FIELD_W-1:0] r_east, r_north;
    logic r_neg;
    logic [4:0] r_k, n_k, w_k_d;
    logic w_neg_d;
    logic signed [63:0] w_east, w_h, w_c, w_s, w_z, w_y, w_yn;
    logic signed [63:0] n_b;
    logic [63:0] n_bsh;

    // ratio reduced by 2^k until it is below two
    always_comb begin
        n_k = 5'd16;
        for (int j = 15; j >= 0; j--) begin
            n_bsh = 64'(r_b) << (j + 1);
            if (n_bsh > 64'(r_a)) n_k = 5'(j);
        end
        n_b = w_c - w_s;
        w_yn = w_neg_d ? -w_y : w_y;
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_lat   <= wmp_pkg::clamp_lat(i_lat, LAT_MAX);
            r_east  <= wmp_pkg::sat_field(w_east + i_cfg.false_easting);
            r_neg   <= w_h[63];
            r_h     <= w_h[63] ? -w_h : w_h;
            r_a     <= w_c + w_s;
            r_b     <= (n_b <= 64'sd0) ? 64'sd1 : n_b;
            r_a2    <= r_a;
            r_b2    <= r_b;
            r_k     <= n_k;
            r_u     <= r_a2 + (r_b2 <<< r_k);
            r_v     <= r_a2 - (r_b2 <<< r_k);
            r_len   <= $signed({59'd0, w_k_d}) * wmp_pkg::LN2_Q60 + (w_z <<< 1);
            r_north <= wmp_pkg::sat_field(w_yn + i_cfg.false_northing);
        end
    end

    wmp_smul #(.SHIFT(46), .LIM(64'(wmp_pkg::LIM62))) u_east (
        .i_clk(i_clk), .i_en(i_en), .i_a(i_lon), .i_b(wmp_pkg::CX46), .o_p(w_east)
    );

    wmp_delay #(.WIDTH(wmp_pkg::FIELD_W), .DEPTH(H + CORDIC_STAGES + 10)) u_east_dly (
        .i_clk(i_clk), .i_en(i_en), .i_d(r_east), .o_q(o_east)
    );

    // half latitude in radians
    wmp_smul #(.SHIFT(FRACTION_BITS + 9), .LIM(64'(wmp_pkg::LIM62))) u_half (
        .i_clk(i_clk), .i_en(i_en), .i_a(r_lat), .i_b(wmp_pkg::KRAD68), .o_p(w_h)
    );

    wmp_delay #(.WIDTH(1), .DEPTH(H + CORDIC_STAGES + 8)) u_neg_dly (
        .i_clk(i_clk), .i_en(i_en), .i_d(r_neg), .o_q(w_neg_d)
    );

    wmp_cordic #(.STAGES(CORDIC_STAGES), .HYP(1'b0), .VEC(1'b0)) u_crot (
        .i_clk(i_clk), .i_en(i_en), .i_x(wmp_pkg::ONE_Q60), .i_y(64'sd0), .i_z(r_h),
        .o_x(w_c), .o_y(w_s), .o_z()
    );

    wmp_delay #(.WIDTH(5), .DEPTH(H + 1)) u_k_dly (
        .i_clk(i_clk), .i_en(i_en), .i_d(r_k), .o_q(w_k_d)
    );

    // artanh of (a - b') / (a + b') is half the log of the reduced ratio
    wmp_cordic #(.STAGES(CORDIC_STAGES), .HYP(1'b1), .VEC(1'b1)) u_hvec (
        .i_clk(i_clk), .i_en(i_en), .i_x(r_u), .i_y(r_v), .i_z(64'sd0),
        .o_x(), .o_y(), .o_z(w_z)
    );

    wmp_smul #(.SHIFT(60 - FRACTION_BITS), .LIM(64'(wmp_pkg::LIM62))) u_north (
        .i_clk(i_clk), .i_en(i_en), .i_a(r_len), .i_b(wmp_pkg::EARTH_R), .o_p(w_y)
    );

    assign o_north = r_north;

endmodule

FILE: hdl/web_mercator_projection.sv
// top level of the spherical web mercator point converter
`timescale 1ns / 1ps

// Takes one point per clock and returns one point per clock whenever the pipeline
// moves. The pipeline depth is set by the two unrolled cordic chains, one circular
// and one hyperbolic (which repeats shifts 4, 13 and 40 where reached), that each
// direction runs in series, one register per iteration, plus the pipelined 64-bit
// multipliers around them. The pipeline moves whenever its last stage is empty or
// the output register can be emptied, so inputs keep flowing while a result waits
// as long as there are bubbles in flight. The user must write configuration only
// while idle; the block itself does not enforce it.
module web_mercator_projection #(
    parameter int FRACTION_BITS = 32,
    parameter int CORDIC_STAGES = 40
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_cfg_wen,
    input  logic [wmp_pkg::CFG_IDX_W-1:0]   i_cfg_idx,
    input  logic [wmp_pkg::FIELD_W-1:0]     i_cfg_data,
    input  logic                            i_s_axis_tvalid,
    output logic                            o_s_axis_tready,
    // coord_first, coord_second, coord_third, zero pad
    input  logic [wmp_pkg::TDATA_W-1:0]     i_s_axis_tdata,
    // action
    input  logic                            i_s_axis_tuser,
    output logic                            o_m_axis_tvalid,
    input  logic                            i_m_axis_tready,
    // result_first, result_second, result_third, zero pad
    output logic [wmp_pkg::TDATA_W-1:0]     o_m_axis_tdata
);

    localparam int LAT = wmp_pkg::path_lat(CORDIC_STAGES);
    localparam int FW  = wmp_pkg::FIELD_W;

    wmp_pkg::t_cfg r_cfg;
    logic [LAT-1:0] r_vld;
    logic r_out_vld;
    logic [wmp_pkg::TDATA_W-1:0] r_out_data, n_out_data;
    logic w_en;
    logic [3*FW+1:0] w_side;
    logic [FW-1:0] w_geo_lat, w_geo_lon, w_prj_east, w_prj_north;

    assign w_en = i_m_axis_tready || !r_out_vld || !r_vld[LAT-1];
    assign o_s_axis_tready = w_en;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg <= '0;
        end else if (i_cfg_wen) begin
            unique case (i_cfg_idx)
                wmp_pkg::REG_MERCATOR_ENABLED: r_cfg.enabled <= i_cfg_data[0];
                wmp_pkg::REG_FALSE_EASTING: r_cfg.false_easting <= wmp_pkg::sext_field(i_cfg_data);
                wmp_pkg::REG_FALSE_NORTHING:
                    r_cfg.false_northing <= wmp_pkg::sext_field(i_cfg_data);
                default: ;
            endcase
        end
    end

    wmp_to_geo #(.FRACTION_BITS(FRACTION_BITS), .CORDIC_STAGES(CORDIC_STAGES)) u_geo (
        .i_clk(i_clk), .i_en(w_en), .i_cfg(r_cfg),
        .i_east(wmp_pkg::sext_field(i_s_axis_tdata[FW-1:0])),
        .i_north(wmp_pkg::sext_field(i_s_axis_tdata[2*FW-1:FW])),
        .o_lat(w_geo_lat), .o_lon(w_geo_lon)
    );

    wmp_to_proj #(.FRACTION_BITS(FRACTION_BITS), .CORDIC_STAGES(CORDIC_STAGES)) u_proj (
        .i_clk(i_clk), .i_en(w_en), .i_cfg(r_cfg),
        .i_lat(wmp_pkg::sext_field(i_s_axis_tdata[FW-1:0])),
        .i_lon(wmp_pkg::sext_field(i_s_axis_tdata[2*FW-1:FW])),
        .o_east(w_prj_east), .o_north(w_prj_north)
    );

    // action, enable and the raw coordinates ride along for pass-through
    wmp_delay #(.WIDTH(3 * FW + 2), .DEPTH(LAT)) u_side (
        .i_clk(i_clk), .i_en(w_en),
        .i_d({i_s_axis_tuser, r_cfg.enabled, i_s_axis_tdata[3*FW-1:0]}),
        .o_q(w_side)
    );

    always_comb begin
        n_out_data = '0;
        n_out_data[3*FW-1:0] = w_side[3*FW-1:0];
        priority if (!w_side[3*FW]) begin
            n_out_data[2*FW-1:0] = w_side[2*FW-1:0];
        end else if (w_side[3*FW+1]) begin
            n_out_data[2*FW-1:0] = {w_prj_north, w_prj_east};
        end else begin
            n_out_data[2*FW-1:0] = {w_geo_lon, w_geo_lat};
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld     <= '0;
            r_out_vld <= 1'b0;
        end else begin
            if (w_en) r_vld <= {r_vld[LAT-2:0], i_s_axis_tvalid};
            if (r_out_vld && i_m_axis_tready) r_out_vld <= 1'b0;
            if (w_en && r_vld[LAT-1]) r_out_vld <= 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en && r_vld[LAT-1]) r_out_data <= n_out_data;
    end

    assign o_m_axis_tvalid = r_out_vld;
    assign o_m_axis_tdata  = r_out_data;

endmodule

FILE: hdl/wmp_checker.sv
// port-level checks for the web mercator block, bound to the top level
`timescale 1ns / 1ps
`include "web_mercator_projection_assert.svh"

module wmp_checker (
    input logic                         i_clk,
    input logic                         i_rst_n,
    input logic                         o_s_axis_tready,
    input logic                         o_m_axis_tvalid,
    input logic                         i_m_axis_tready,
    input logic [wmp_pkg::TDATA_W-1:0]  o_m_axis_tdata
);

    // a stalled result stays and holds its data
    `WMP_ASSERT_NEXT(a_stall_hold, o_m_axis_tvalid && !i_m_axis_tready, o_m_axis_tvalid && $stable(o_m_axis_tdata))
    // a result only leaves once taken
    `WMP_ASSERT_NOW(a_leave_taken, $fell(o_m_axis_tvalid), $past(i_m_axis_tready))
    // an empty output register never blocks the input
    `WMP_ASSERT_NOW(a_empty_ready, !o_m_axis_tvalid, o_s_axis_tready)
    // a ready sink never blocks the input
    `WMP_ASSERT_NOW(a_sink_ready, i_m_axis_tready, o_s_axis_tready)

endmodule

bind web_mercator_projection wmp_checker u_wmp_checker (
    .i_clk(i_clk),
    .i_rst_n(i_rst_n),
    .o_s_axis_tready(o_s_axis_tready),
    .o_m_axis_tvalid(o_m_axis_tvalid),
    .i_m_axis_tready(i_m_axis_tready),
    .o_m_axis_tdata(o_m_axis_tdata)
);

FILE: bench/tb.sv
// self-checking testbench for the web mercator point converter
`timescale 1ns / 1ps

module tb;

    typedef logic signed [63:0] t_s64;
    typedef logic signed [wmp_pkg::FIELD_W-1:0] t_fld;

    typedef struct {
        logic act;
        t_fld coord [3];
        t_fld want  [3];
    } t_point;

    localparam logic ACT_TO_GEO  = 1'b0;
    localparam logic ACT_TO_PROJ = 1'b1;

    localparam int RX_ALWAYS = 0;
    localparam int RX_COIN   = 1;
    localparam int RX_SPARSE = 2;

    localparam int DRAIN_CYCLES = 110;
    localparam int LONG_HOLD    = 400;
    localparam int CYCLE_LIMIT  = 300000;

    localparam t_s64 PI_FX  = 64'sh3243_F6A8_885A_308D;
    localparam t_s64 LN2_FX = 64'sh0B17_217F_7D1C_F79B;
    localparam t_s64 ONE_FX = 64'sh1000_0000_0000_0000;
    localparam t_s64 SAT62  = 64'sh4000_0000_0000_0000;
    localparam t_s64 RADIUS = 64'sd6378137;
    localparam int NSTG   = 40;
    localparam int FB     = 32;

    logic                             i_clk = 1'b0;
    logic                             i_rst_n = 1'b0;
    logic                             i_cfg_wen = 1'b0;
    logic [wmp_pkg::CFG_IDX_W-1:0]    i_cfg_idx = '0;
    logic [wmp_pkg::FIELD_W-1:0]      i_cfg_data = '0;
    logic                             i_s_axis_tvalid = 1'b0;
    logic                             o_s_axis_tready;
    logic [wmp_pkg::TDATA_W-1:0]      i_s_axis_tdata = '0;
    logic                             i_s_axis_tuser = 1'b0;
    logic                             o_m_axis_tvalid;
    logic                             i_m_axis_tready = 1'b0;
    logic [wmp_pkg::TDATA_W-1:0]      o_m_axis_tdata;

    web_mercator_projection i_dut (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cfg_wen      (i_cfg_wen),
        .i_cfg_idx      (i_cfg_idx),
        .i_cfg_data     (i_cfg_data),
        .i_s_axis_tvalid(i_s_axis_tvalid),
        .o_s_axis_tready(o_s_axis_tready),
        .i_s_axis_tdata (i_s_axis_tdata),
        .i_s_axis_tuser (i_s_axis_tuser),
        .o_m_axis_tvalid(o_m_axis_tvalid),
        .i_m_axis_tready(i_m_axis_tready),
        .o_m_axis_tdata (o_m_axis_tdata)
    );

    initial begin
        forever #5 i_clk = ~i_clk;
    end

    // converter settings as last written
    logic merc_on = 1'b0;
    t_s64 east_off = '0;
    t_s64 north_off = '0;

    // arithmetic constants of the conversion
    t_s64 atan_q60 [0:63];
    t_s64 atanh_q60 [0:63];
    t_s64 deg_per_rad_q57, rad_per_deg_q68, inv_r_q85, deg_per_m_q78, m_per_deg_q46, lat_lim;

    t_point feed_q [$];
    t_point pending_q [$];
    t_point cur_req;
    bit     tx_busy = 1'b0;
    int     gap_left = 0;
    int     burst_left = 0;
    int     errors = 0;
    int     cycles = 0;
    bit     hold_req = 1'b0;

    function automatic t_s64 arc_series(int i, bit alternating);
        logic [63:0] sum;
        logic [63:0] t;
        int e;
        sum = '0;
        for (int k = 0; k < 32; k++) begin
            e = i * (2 * k + 1);
            if (e <= 63) begin
                t = (64'd1 << (63 - e)) / 64'(2 * k + 1);
                sum = (alternating && k[0]) ? sum - t : sum + t;
            end
        end
        return t_s64'((sum + 64'd4) >> 3);
    endfunction

    task automatic setup_constants();
        logic [127:0] w;
        atan_q60[0] = t_s64'((64'(PI_FX) + 64'd2) >> 2);
        atanh_q60[0] = '0;
        for (int i = 1; i < 64; i++) begin
            atan_q60[i] = arc_series(i, 1'b1);
            atanh_q60[i] = arc_series(i, 1'b0);
        end
        w = (128'd180 << 117) / {64'd0, 64'(PI_FX)};
        deg_per_rad_q57 = t_s64'(w[63:0]);
        w = ({64'd0, 64'(PI_FX)} << 8) / 128'd180;
        rad_per_deg_q68 = t_s64'(w[63:0]);
        w = (128'd1 << 85) / {64'd0, 64'(RADIUS)};
        inv_r_q85 = t_s64'(w[63:0]);
        w = ({64'd0, 64'(deg_per_rad_q57)} * {64'd0, 64'(inv_r_q85)} + (128'd1 << 63)) >> 64;
        deg_per_m_q78 = t_s64'(w[63:0]);
        w = ({64'd0, 64'(RADIUS)} * {64'd0, 64'(rad_per_deg_q68)} + (128'd1 << 21)) >> 22;
        m_per_deg_q46 = t_s64'(w[63:0]);
        lat_lim = t_s64'((64'd85 << FB) +
                         (((64'd5112878 << FB) + 64'd50000000) / 64'd100000000));
    endtask

    // magnitude product rounded half away from zero, capped at lim
    function automatic t_s64 scaled_mul(t_s64 a, t_s64 b, int sh, t_s64 lim);
        logic [127:0] p;
        logic neg;
        neg = (a < 0) != (b < 0);
        p = {64'd0, 64'(a < 0 ? -a : a)} * {64'd0, 64'(b < 0 ? -b : b)};
        p = (p + (128'd1 << (sh - 1))) >> sh;
        if (p > {64'd0, 64'(lim)}) p = {64'd0, 64'(lim)};
        return neg ? -t_s64'(p[63:0]) : t_s64'(p[63:0]);
    endfunction

    function automatic t_fld to_field(t_s64 v);
        if (v > wmp_pkg::FIELD_MAX) return t_fld'(wmp_pkg::FIELD_MAX);
        if (v < wmp_pkg::FIELD_MIN) return t_fld'(wmp_pkg::FIELD_MIN);
        return t_fld'(v);
    endfunction

    function automatic t_s64 limit_lat(t_s64 v);
        if (v > lat_lim) return lat_lim;
        if (v < -lat_lim) return -lat_lim;
        return v;
    endfunction

    function automatic void circ_rot(t_s64 z, output t_s64 c, output t_s64 s);
        t_s64 x, y, dx, dy;
        x = ONE_FX;
        y = '0;
        for (int i = 0; i < NSTG; i++) begin
            dx = y >>> i;
            dy = x >>> i;
            if (z >= 0) begin x -= dx; y += dy; z -= atan_q60[i]; end
            else begin x += dx; y -= dy; z += atan_q60[i]; end
        end
        c = x;
        s = y;
    endfunction

    function automatic t_s64 circ_angle(t_s64 x, t_s64 y);
        t_s64 z, dx, dy;
        z = '0;
        for (int i = 0; i < NSTG; i++) begin
            dx = y >>> i;
            dy = x >>> i;
            if (y >= 0) begin x += dx; y -= dy; z += atan_q60[i]; end
            else begin x -= dx; y += dy; z -= atan_q60[i]; end
        end
        return z;
    endfunction

    function automatic void hyp_rot(t_s64 z, output t_s64 c, output t_s64 s);
        t_s64 x, y, dx, dy;
        x = ONE_FX;
        y = '0;
        for (int i = 1; i <= NSTG; i++) begin
            for (int r = 0; r < ((i == 4 || i == 13 || i == 40) ? 2 : 1); r++) begin
                dx = y >>> i;
                dy = x >>> i;
                if (z >= 0) begin x += dx; y += dy; z -= atanh_q60[i]; end
                else begin x -= dx; y -= dy; z += atanh_q60[i]; end
            end
        end
        c = x;
        s = y;
    endfunction

    function automatic t_s64 hyp_angle(t_s64 x, t_s64 y);
        t_s64 z, dx, dy;
        z = '0;
        for (int i = 1; i <= NSTG; i++) begin
            for (int r = 0; r < ((i == 4 || i == 13 || i == 40) ? 2 : 1); r++) begin
                dx = y >>> i;
                dy = x >>> i;
                if (y >= 0) begin x -= dx; y -= dy; z += atanh_q60[i]; end
                else begin x += dx; y += dy; z -= atanh_q60[i]; end
            end
        end
        return z;
    endfunction

    function automatic void convert_point(ref t_point p);
        t_s64 f, g, x, y, w, c, s, vx, vy, h, a, b, bp, z, len, north;
        logic neg;
        int k;
        f = p.coord[0];
        g = p.coord[1];
        p.want[0] = p.coord[0];
        p.want[1] = p.coord[1];
        p.want[2] = p.coord[2];
        if (merc_on && p.act == ACT_TO_GEO) begin
            x = f - east_off;
            y = g - north_off;
            p.want[1] = to_field(scaled_mul(x, deg_per_m_q78, 78, SAT62));
            w = scaled_mul(y, inv_r_q85, FB + 27, ONE_FX);
            hyp_rot(w, c, s);
            vx = scaled_mul(c, c, 61, SAT62) + scaled_mul(s, s, 61, SAT62);
            vy = scaled_mul(c, s, 60, SAT62);
            p.want[0] = t_fld'(limit_lat(scaled_mul(circ_angle(vx, vy), deg_per_rad_q57,
                                                    116 - FB, SAT62)));
        end else if (merc_on) begin
            p.want[0] = to_field(scaled_mul(g, m_per_deg_q46, 46, SAT62) + east_off);
            h = scaled_mul(limit_lat(f), rad_per_deg_q68, FB + 9, SAT62);
            neg = h < 0;
            if (neg) h = -h;
            circ_rot(h, c, s);
            a = c + s;
            b = c - s;
            if (b <= 0) b = 1;
            k = 0;
            while (k < 16 && ((64'(b) << (k + 1)) <= 64'(a))) k++;
            bp = t_s64'(64'(b) << k);
            z = hyp_angle(a + bp, a - bp);
            len = t_s64'(k) * LN2_FX + 2 * z;
            north = scaled_mul(len, RADIUS, 60 - FB, SAT62);
            if (neg) north = -north;
            p.want[1] = to_field(north + north_off);
        end
    endfunction

    // request driver: bursts of random length with random gaps
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_s_axis_tvalid <= 1'b0;
        end else begin
            if (tx_busy && o_s_axis_tready) begin
                pending_q.push_back(cur_req);
                tx_busy = 1'b0;
            end
            if (!tx_busy) begin
                if (gap_left > 0) begin
                    gap_left--;
                    i_s_axis_tvalid <= 1'b0;
                end else if (feed_q.size() > 0) begin
                    cur_req = feed_q.pop_front();
                    i_s_axis_tvalid <= 1'b1;
                    i_s_axis_tuser <= cur_req.act;
                    i_s_axis_tdata <= {2'b00, cur_req.coord[2], cur_req.coord[1],
                                       cur_req.coord[0]};
                    tx_busy = 1'b1;
                    if (burst_left > 0) begin
                        burst_left--;
                    end else begin
                        burst_left = $urandom_range(1, 30);
                        gap_left = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
                    end
                end else begin
                    i_s_axis_tvalid <= 1'b0;
                end
            end
        end
    end

    // result sink stall pattern
    int rx_mode = RX_ALWAYS;
    int mode_left = 0;
    int hold_left = 0;
    always @(posedge i_clk) begin
        if (hold_req) begin
            hold_left = LONG_HOLD;
            hold_req = 1'b0;
        end
        if (!i_rst_n) begin
            i_m_axis_tready <= 1'b0;
        end else if (hold_left > 0) begin
            hold_left--;
            i_m_axis_tready <= 1'b0;
        end else begin
            if (mode_left == 0) begin
                rx_mode = $urandom_range(RX_ALWAYS, RX_SPARSE);
                mode_left = $urandom_range(20, 120);
            end
            mode_left--;
            case (rx_mode)
                RX_ALWAYS: i_m_axis_tready <= 1'b1;
                RX_COIN:   i_m_axis_tready <= $urandom_range(0, 1);
                default:   i_m_axis_tready <= ($urandom_range(0, 9) < 2);
            endcase
        end
    end

    // result checker
    always @(posedge i_clk) begin
        t_point exp_pt;
        t_fld got [3];
        if (i_rst_n && o_m_axis_tvalid && i_m_axis_tready) begin
            got[0] = o_m_axis_tdata[wmp_pkg::FIELD_W-1:0];
            got[1] = o_m_axis_tdata[2*wmp_pkg::FIELD_W-1:wmp_pkg::FIELD_W];
            got[2] = o_m_axis_tdata[3*wmp_pkg::FIELD_W-1:2*wmp_pkg::FIELD_W];
            if (pending_q.size() == 0) begin
                errors++;
                $display("%0t: unexpected result, expected none, actual %h", $time,
                         o_m_axis_tdata);
            end else begin
                exp_pt = pending_q.pop_front();
                for (int i = 0; i < 3; i++) begin
                    if (got[i] !== exp_pt.want[i]) begin
                        errors++;
                        $display("%0t: result field %0d mismatch, expected %h actual %h",
                                 $time, i, exp_pt.want[i], got[i]);
                    end
                end
            end
        end
    end

    always @(posedge i_clk) begin
        cycles++;
        if (cycles > CYCLE_LIMIT) begin
            $display("TEST FAILED");
            $finish;
        end
    end

    function automatic t_fld deg_fx(real r);
        return t_fld'(longint'(r * 4294967296.0));
    endfunction

    function automatic t_fld any_field();
        return t_fld'({$urandom, $urandom});
    endfunction

    // integer part in [-span, span] plus a random fraction
    function automatic t_fld near_field(int span);
        t_s64 v;
        v = t_s64'($urandom_range(0, 2 * span)) - span;
        return t_fld'((v <<< FB) | t_s64'($urandom));
    endfunction

    task automatic send_point(logic act, t_fld f, t_fld g, t_fld t);
        t_point p;
        p.act = act;
        p.coord[0] = f;
        p.coord[1] = g;
        p.coord[2] = t;
        convert_point(p);
        feed_q.push_back(p);
        while (feed_q.size() > 4) @(posedge i_clk);
    endtask

    task automatic wait_idle();
        while (feed_q.size() != 0 || tx_busy || pending_q.size() != 0) @(posedge i_clk);
    endtask

    task automatic write_reg(logic [wmp_pkg::CFG_IDX_W-1:0] idx, t_fld val);
        wait_idle();
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        i_cfg_wen <= 1'b1;
        i_cfg_idx <= idx;
        i_cfg_data <= val;
        @(posedge i_clk);
        i_cfg_wen <= 1'b0;
        case (idx)
            wmp_pkg::REG_MERCATOR_ENABLED: merc_on = val[0];
            wmp_pkg::REG_FALSE_EASTING:    east_off = val;
            wmp_pkg::REG_FALSE_NORTHING:   north_off = val;
            default: ;
        endcase
    endtask

    task automatic set_mode(logic on, t_fld fe, t_fld fn);
        write_reg(wmp_pkg::REG_MERCATOR_ENABLED, t_fld'(on));
        write_reg(wmp_pkg::REG_FALSE_EASTING, fe);
        write_reg(wmp_pkg::REG_FALSE_NORTHING, fn);
    endtask

    task automatic test_passthrough();
        send_point(ACT_TO_GEO, t_fld'(wmp_pkg::FIELD_MAX), t_fld'(wmp_pkg::FIELD_MIN), '0);
        send_point(ACT_TO_PROJ, t_fld'(wmp_pkg::FIELD_MIN), t_fld'(wmp_pkg::FIELD_MAX), '1);
        send_point(ACT_TO_GEO, '0, '1, t_fld'(wmp_pkg::FIELD_MAX));
        send_point(ACT_TO_PROJ, deg_fx(45.0), deg_fx(-120.0), t_fld'(wmp_pkg::FIELD_MIN));
    endtask

    task automatic test_directed_geo();
        send_point(ACT_TO_GEO, '0, '0, deg_fx(12.5));
        send_point(ACT_TO_GEO, deg_fx(20037508.34), deg_fx(20037508.34), '0);
        send_point(ACT_TO_GEO, deg_fx(-20037508.34), deg_fx(-20037508.34), '0);
        send_point(ACT_TO_GEO, t_fld'(wmp_pkg::FIELD_MAX), t_fld'(wmp_pkg::FIELD_MAX), '1);
        send_point(ACT_TO_GEO, t_fld'(wmp_pkg::FIELD_MIN), t_fld'(wmp_pkg::FIELD_MIN), '1);
        send_point(ACT_TO_GEO, deg_fx(1.0), deg_fx(-0.5), '0);
    endtask

    task automatic test_directed_proj();
        send_point(ACT_TO_PROJ, '0, '0, '0);
        send_point(ACT_TO_PROJ, deg_fx(85.05112878), deg_fx(180.0), '0);
        send_point(ACT_TO_PROJ, deg_fx(-85.05112878), deg_fx(-180.0), '0);
        send_point(ACT_TO_PROJ, deg_fx(90.0), deg_fx(0.001), '0);
        send_point(ACT_TO_PROJ, deg_fx(-90.0), deg_fx(-0.001), '0);
        send_point(ACT_TO_PROJ, t_fld'(wmp_pkg::FIELD_MAX), t_fld'(wmp_pkg::FIELD_MAX), '0);
        send_point(ACT_TO_PROJ, t_fld'(wmp_pkg::FIELD_MIN), t_fld'(wmp_pkg::FIELD_MIN), '0);
        send_point(ACT_TO_PROJ, deg_fx(-1.0e-9), deg_fx(51.5), '0);
    endtask

    task automatic test_offset_extremes();
        set_mode(1'b1, t_fld'(wmp_pkg::FIELD_MAX), t_fld'(wmp_pkg::FIELD_MIN));
        send_point(ACT_TO_GEO, '0, '0, '0);
        send_point(ACT_TO_PROJ, deg_fx(60.0), deg_fx(170.0), '0);
        send_point(ACT_TO_PROJ, deg_fx(-60.0), deg_fx(-170.0), '0);
        set_mode(1'b1, t_fld'(wmp_pkg::FIELD_MIN), t_fld'(wmp_pkg::FIELD_MAX));
        send_point(ACT_TO_GEO, t_fld'(wmp_pkg::FIELD_MAX), t_fld'(wmp_pkg::FIELD_MIN), '0);
        send_point(ACT_TO_PROJ, deg_fx(-60.0), deg_fx(-170.0), '0);
        send_point(ACT_TO_PROJ, deg_fx(60.0), deg_fx(170.0), '0);
    endtask

    task automatic random_point();
        logic act;
        act = $urandom_range(0, 1);
        if ($urandom_range(0, 9) < 3)
            send_point(act, any_field(), any_field(), any_field());
        else if (act == ACT_TO_GEO)
            send_point(act, near_field(21000000), near_field(21000000), any_field());
        else
            send_point(act, near_field(95), near_field(190), any_field());
    endtask

    task automatic test_random(int n);
        for (int i = 0; i < n; i++) random_point();
    endtask

    task automatic test_backpressure();
        hold_req = 1'b1;
        for (int i = 0; i < 200; i++) random_point();
        wait_idle();
    endtask

    initial begin
        setup_constants();
        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        test_passthrough();
        set_mode(1'b1, '0, '0);
        test_directed_geo();
        test_directed_proj();
        test_offset_extremes();
        set_mode(1'b1, near_field(5000000), near_field(5000000));
        test_random(240);
        test_backpressure();
        set_mode(1'b0, near_field(1000), near_field(1000));
        test_random(200);
        set_mode(1'b1, '0, '0);
        test_random(280);
        set_mode(1'b1, any_field(), any_field());
        test_random(240);
        set_mode(1'b1, near_field(30000000), near_field(30000000));
        test_random(240);
        wait_idle();
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (errors == 0 && pending_q.size() == 0) begin
            $display("TEST PASSED");
        end else begin
            $display("TEST FAILED");
        end
        $finish;
    end

endmodule

FILE: files.f
+incdir+hdl
hdl/wmp_pkg.sv
hdl/wmp_smul.sv
hdl/wmp_delay.sv
hdl/wmp_cordic.sv
hdl/wmp_to_geo.sv
hdl/wmp_to_proj.sv
hdl/web_mercator_projection.sv
hdl/wmp_checker.sv
bench/tb.sv
